// File: hw/rtl/sabs_pkg.sv
// Package for the sorted array binary search block.
// Sizes, bound type and controller/datapath command and status structs.
// No dependencies.
package sabs_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BND_W   = IDX_W + 2;   // signed bound: -1 .. ENTRIES
    localparam int DATA_W  = 32;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef logic signed [BND_W-1:0] bound_t;
    typedef logic        [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic load_wr;   // write value at load position
        logic start;     // capture key, open full bounds
        logic step;      // narrow bounds after a miss
        logic finish;    // capture found flag
    } dp_cmd_t;

    typedef struct packed {
        logic hit;       // probe equals key, bounds non-empty
        logic empty;     // low > high
    } dp_sts_t;

endpackage

// File: hw/rtl/sabs_if.sv
// Handshake channels for the binary search block.
// Depends on sabs_pkg.
interface sabs_req_if;
    import sabs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface sabs_rsp_if;
    logic valid;
    logic ready;
    logic found;
    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

// File: hw/rtl/sabs_dp.sv
// Datapath: entry store, load position, search bounds, key and result.
// Depends on sabs_pkg.
module sabs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sabs_pkg::dp_cmd_t                 cmd,
    input  logic signed [sabs_pkg::DATA_W-1:0] value,
    output sabs_pkg::dp_sts_t                 sts,
    output logic                              found
);
    import sabs_pkg::*;

    logic signed [DATA_W-1:0] entry_reg [ENTRIES];
    logic signed [DATA_W-1:0] key_reg;
    idx_t                     pos_reg, pos_next;
    bound_t                   low_reg, low_next;
    bound_t                   high_reg, high_next;
    bound_t                   mid;
    logic signed [DATA_W-1:0] probe;
    logic                     found_reg;

    // midpoint = low + (high - low) / 2; span is non-negative when used
    assign mid   = low_reg + ((high_reg - low_reg) >>> 1);
    assign probe = entry_reg[mid[IDX_W-1:0]];

    assign sts.empty = low_reg > high_reg;
    assign sts.hit   = !sts.empty && (probe == key_reg);
    assign found     = found_reg;

    always_comb
    begin
        if (pos_reg == idx_t'(ENTRIES - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + idx_t'(1);
        end

        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.start)
        begin
            low_next  = '0;
            high_next = bound_t'(ENTRIES - 1);
        end
        else if (cmd.step)
        begin
            if (probe < key_reg)
            begin
                low_next = mid + bound_t'(1);
            end
            else
            begin
                high_next = mid - bound_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load_wr)
        begin
            pos_reg <= pos_next;
        end
    end

    // entry store: one write port, one read port at the midpoint
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            entry_reg[pos_reg] <= value;
        end
        if (cmd.start)
        begin
            key_reg <= value;
        end
        if (cmd.finish)
        begin
            found_reg <= sts.hit;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
    end

endmodule

// File: hw/rtl/sabs_ctrl.sv
// Controller: decodes input transfers, sequences probes, owns result valid.
// Depends on sabs_pkg.
module sabs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_func,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  sabs_pkg::dp_sts_t sts,
    output sabs_pkg::dp_cmd_t cmd
);
    import sabs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   req_xfer;
    logic   done;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign done      = sts.hit || sts.empty;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req_func == FUNC_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!done)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_step_not_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.finish))
        else $error("step and finish together");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid_reg)
        else $error("result not presented after finish");

    a_finish_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (done && slot_free))
        else $error("finish while search open or slot busy");

    a_start_leads_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_SEARCH && !req_ready))
        else $error("search not entered after start");
`endif

endmodule

// File: hw/rtl/sorted_array_binary_search_top.sv
// Top level of the sorted array binary search block.
// Depends on sabs_pkg, sabs_if, sabs_ctrl and sabs_dp.
//
// Usage:
//   req (sink): func = 0 loads value at the load position, which then
//   advances and wraps after the last of ENTRIES entries; func = 1 searches
//   for value as key over all ENTRIES entries. A load gives no result.
//   rsp (source): one transfer per search, found = 1 when an entry equal
//   to the key was met.
// Timing:
//   req.ready stays high for back-to-back loads. A search holds req.ready
//   low while it probes, and a missed key takes a closing step once the
//   bounds are empty. Each probe step reads one entry, compares it with
//   the key and updates the bounds. The result appears in rsp the cycle
//   after the hit probe or the closing step and sits in an output
//   register, so the next item is taken while it waits.
// Stall:
//   If rsp.ready is low and a result is still waiting, a finished search
//   holds until that result is taken; nothing is dropped.
// Reset:
//   rst_n clears the load position, the controller and rsp.valid. Entries
//   are not cleared; they must be loaded before they are searched.
module sorted_array_binary_search_top (
    input logic        clk,
    input logic        rst_n,
    sabs_req_if.sink   req,
    sabs_rsp_if.source rsp
);
    import sabs_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // controller: accepts transfers, sequences the probes
    sabs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: entry store, bounds, key compare, result register
    sabs_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (req.value),
        .sts   (sts),
        .found (rsp.found)
    );

endmodule
